// ----- rtl/uvc16_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package uvc16_pkg;

	// component width, two's complement
	localparam int COMPONENT_WIDTH = 16;

	// magnitude sum of three components
	localparam int SUM_W = COMPONENT_WIDTH + 2;
	// partial remainder, holds 126 * magnitude and sum shifted by up to six
	localparam int REM_W = COMPONENT_WIDTH + 8;

	// quotient bits of floor(126 * a / s), at most 126
	localparam int QBITS   = 7;
	localparam int SCALE   = 126;
	localparam int FOLD_AT = 64;
	localparam int FOLD_TO = 127;

	localparam int CODE_W = 16;
	localparam int XF_W   = 6;

	typedef struct packed {
		logic [COMPONENT_WIDTH-1:0] x_component;
		logic [COMPONENT_WIDTH-1:0] y_component;
		logic [COMPONENT_WIDTH-1:0] z_component;
	} vec_t;

	typedef struct packed {
		logic [CODE_W-1:0] packed_code;
		logic              zero_vector;
	} code_t;

	// one divider stage: both lanes share the divisor
	typedef struct packed {
		logic [2:0]       sgn;
		logic [SUM_W-1:0] sum;
		logic [REM_W-1:0] rem_x;
		logic [REM_W-1:0] rem_y;
		logic [QBITS-1:0] quo_x;
		logic [QBITS-1:0] quo_y;
	} div_t;

endpackage
`default_nettype wire

// ----- rtl/uvc16_vec_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface uvc16_vec_if import uvc16_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [COMPONENT_WIDTH-1:0] x_component;
	logic [COMPONENT_WIDTH-1:0] y_component;
	logic [COMPONENT_WIDTH-1:0] z_component;

	modport source (output valid, output x_component, output y_component,
		output z_component, input ready);
	modport sink (input valid, input x_component, input y_component,
		input z_component, output ready);
endinterface
`default_nettype wire

// ----- rtl/uvc16_code_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface uvc16_code_if import uvc16_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] packed_code;
	logic              zero_vector;

	modport source (output valid, output packed_code, output zero_vector, input ready);
	modport sink (input valid, input packed_code, input zero_vector, output ready);
endinterface
`default_nettype wire

// ----- rtl/unit_vector_compress_16bit_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Unit vector compressor: each beat on vec carries a signed x, y, z direction and
// produces one beat on code: the three sign bits on top, then the vector projected
// onto x+y+z=1 as floor(126*|c|/(|x|+|y|+|z|)) for x and y, folded into a rectangle
// when x reaches 64 (x and y become 127 minus themselves), x in bits 12..7 and y in
// bits 6..0. An all-zero vector gives code 0 with zero_vector set. The pipeline is
// ten stages deep: magnitudes, sum and numerators, seven restoring-division stages
// that each settle one quotient bit for both lanes at once, and the fold/pack output
// register. It takes one vector every cycle while code is not stalled. Every
// stage has its own valid bit and moves when the stage ahead is empty or moving,
// so bubbles close up and the input keeps flowing while a finished result waits
// on code.
module unit_vector_compress_16bit_top import uvc16_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	uvc16_vec_if.sink       vec,
	uvc16_code_if.source    code
);

	// stage 1: sign bits and magnitudes
	logic                       vld_s1;
	logic [2:0]                 sgn_s1;
	logic [COMPONENT_WIDTH-1:0] ax_s1, ay_s1, az_s1;

	// stage 2: divisor and scaled numerators, feeds divider stage 0
	logic vld_s2;
	div_t div_in_s2;

	// divider stages s3 onward, one quotient bit each
	logic [QBITS-1:0] vld_div_s;
	div_t             div_s [QBITS];

	// output register
	logic  vld_out_q;
	code_t out_q;

	// per-stage advance, chained back from the output
	logic             adv_out;
	logic [QBITS-1:0] adv_div;
	logic             adv_s2, adv_s1;

	assign adv_out = !vld_out_q || code.ready;
	assign adv_div[QBITS-1] = !vld_div_s[QBITS-1] || adv_out;
	for (genvar k = 0; k < QBITS-1; k++) begin : g_adv
		assign adv_div[k] = !vld_div_s[k] || adv_div[k+1];
	end
	assign adv_s2 = !vld_s2 || adv_div[0];
	assign adv_s1 = !vld_s1 || adv_s2;
	assign vec.ready = adv_s1;

	// magnitude of a two's complement component; the most negative value stays exact
	function automatic logic [COMPONENT_WIDTH-1:0] mag(input logic [COMPONENT_WIDTH-1:0] v);
		mag = v[COMPONENT_WIDTH-1] ? (~v + COMPONENT_WIDTH'(1)) : v;
	endfunction

	// 126*a as (a<<7) - (a<<1)
	function automatic logic [REM_W-1:0] scale126(input logic [COMPONENT_WIDTH-1:0] a);
		logic [REM_W-1:0] e;
		e = REM_W'(a);
		scale126 = (e << 7) - (e << 1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= vec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && vec.valid) begin
			sgn_s1 <= {vec.x_component[COMPONENT_WIDTH-1], vec.y_component[COMPONENT_WIDTH-1],
				vec.z_component[COMPONENT_WIDTH-1]};
			ax_s1  <= mag(vec.x_component);
			ay_s1  <= mag(vec.y_component);
			az_s1  <= mag(vec.z_component);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			div_in_s2.sgn   <= sgn_s1;
			div_in_s2.sum   <= SUM_W'(ax_s1) + SUM_W'(ay_s1) + SUM_W'(az_s1);
			div_in_s2.rem_x <= scale126(ax_s1);
			div_in_s2.rem_y <= scale126(ay_s1);
			div_in_s2.quo_x <= '0;
			div_in_s2.quo_y <= '0;
		end
	end

	// restoring division, most significant quotient bit first
	for (genvar k = 0; k < QBITS; k++) begin : g_div
		localparam int SH = QBITS - 1 - k;
		div_t             prev;
		logic             prev_vld;
		logic [REM_W-1:0] trial;
		logic             ge_x, ge_y;
		div_t             nxt;

		if (k == 0) begin : g_first
			assign prev     = div_in_s2;
			assign prev_vld = vld_s2;
		end else begin : g_rest
			assign prev     = div_s[k-1];
			assign prev_vld = vld_div_s[k-1];
		end

		assign trial = REM_W'(prev.sum) << SH;
		assign ge_x  = prev.rem_x >= trial;
		assign ge_y  = prev.rem_y >= trial;

		always_comb begin
			nxt            = prev;
			nxt.rem_x      = ge_x ? prev.rem_x - trial : prev.rem_x;
			nxt.rem_y      = ge_y ? prev.rem_y - trial : prev.rem_y;
			nxt.quo_x[SH]  = ge_x;
			nxt.quo_y[SH]  = ge_y;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_div_s[k] <= 1'b0;
			end else if (adv_div[k]) begin
				vld_div_s[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv_div[k] && prev_vld) begin
				div_s[k] <= nxt;
			end
		end
	end

	// fold and pack
	div_t             fin;
	logic             is_zero;
	logic             fold;
	logic [QBITS-1:0] xf, yf;
	code_t            packed_nxt;

	assign fin     = div_s[QBITS-1];
	assign is_zero = fin.sum == '0;
	assign fold    = fin.quo_x >= QBITS'(FOLD_AT);
	assign xf      = fold ? QBITS'(FOLD_TO) - fin.quo_x : fin.quo_x;
	assign yf      = fold ? QBITS'(FOLD_TO) - fin.quo_y : fin.quo_y;

	always_comb begin
		packed_nxt.zero_vector = is_zero;
		if (is_zero) begin
			packed_nxt.packed_code = {fin.sgn, (CODE_W-3)'(0)};
		end else begin
			packed_nxt.packed_code = {fin.sgn, xf[XF_W-1:0], yf};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (adv_out) begin
			vld_out_q <= vld_div_s[QBITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && vld_div_s[QBITS-1]) begin
			out_q <= packed_nxt;
		end
	end

	assign code.valid       = vld_out_q;
	assign code.packed_code = out_q.packed_code;
	assign code.zero_vector = out_q.zero_vector;

endmodule
`default_nettype wire

// ----- rtl/uvc16_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module uvc16_checker import uvc16_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              out_valid,
	input wire              out_ready,
	input wire [CODE_W-1:0] packed_code,
	input wire              zero_vector
);

	logic [QBITS:0] field_sum;
	assign field_sum = (QBITS+1)'(packed_code[CODE_W-4:QBITS]) +
		(QBITS+1)'(packed_code[QBITS-1:0]);

	// pipeline is empty while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result beat during reset");

	// a zero vector has no signs and no projection
	a_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_vector |-> packed_code == '0)
		else $error("zero vector with nonzero code");

	// unfolded fields sum to at most 126, folded ones to at least 128
	a_fold_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_vector |-> field_sum != (QBITS+1)'(FOLD_TO))
		else $error("projected fields land on the fold seam");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packed_code) && $stable(zero_vector))
		else $error("result beat changed under stall");

endmodule

bind unit_vector_compress_16bit_top uvc16_checker u_uvc16_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (code.valid),
	.out_ready   (code.ready),
	.packed_code (code.packed_code),
	.zero_vector (code.zero_vector)
);
`default_nettype wire
